// ----- hw/rtl/chcb_pkg.sv -----
package chcb_pkg;

    localparam int SYM_W  = 8;
    localparam int LEN_W  = 4;
    localparam int CODE_W = 15;

    // length bins 1..15 give 15 first-code steps
    localparam int NUM_STEPS = 15;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic             op;
        logic [SYM_W-1:0] symbol;
        logic [LEN_W-1:0] code_length;
        logic             last;
    } t_in;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  code_bits;
        logic              present;
        logic              oversubscribed;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HIST,
        S_STEP,
        S_ASSIGN
    } t_state;

    // sequencer commands to the code generator
    typedef struct packed {
        logic             clear;
        logic             hist_en;
        logic             step_en;
        logic             assign_en;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] step_idx;
    } t_gen_ctl;

endpackage

// ----- hw/rtl/chcb_len_store.sv -----
module chcb_len_store #(
    parameter int DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic                           i_we,
    input  logic [$clog2(DEPTH)-1:0]       i_waddr,
    input  logic [chcb_pkg::LEN_W-1:0]     i_wdata,
    input  logic [$clog2(DEPTH)-1:0]       i_raddr,
    output logic [chcb_pkg::LEN_W-1:0]     o_rdata
);

    logic [chcb_pkg::LEN_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]           r_vld;
    logic [DEPTH-1:0]           n_vld;
    logic [chcb_pkg::LEN_W-1:0] r_rdata;

    // valid bits: an entry not written since the last clear reads as zero
    always_comb begin
        n_vld = i_clear ? '0 : r_vld;
        if (i_we) begin
            n_vld[i_waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/chcb_code_gen.sv -----
module chcb_code_gen #(
    parameter int DEPTH     = 256,
    parameter int LEN_LIMIT = 15
) (
    input  logic                          i_clk,
    input  chcb_pkg::t_gen_ctl            i_ctl,
    output logic [chcb_pkg::CODE_W-1:0]   o_code,
    output logic                          o_oversub
);

    localparam int AW = $clog2(DEPTH);
    localparam int HW = $clog2(DEPTH + 1);
    localparam int KW = AW + LEN_LIMIT + 1;
    localparam int CW = chcb_pkg::CODE_W;
    localparam int LW = chcb_pkg::LEN_W;
    localparam logic [KW-1:0] KRAFT_FULL = KW'(1) << LEN_LIMIT;

    logic [HW-1:0] r_hist [16];
    logic [CW-1:0] r_next [16];
    logic [CW-1:0] r_code;
    logic [KW-1:0] r_kraft;

    logic [LW-1:0] w_hidx;
    logic [HW-1:0] w_hval;
    logic [CW-1:0] w_nval;
    logic [CW-1:0] w_a;
    logic [CW-1:0] w_b;
    logic [CW-1:0] w_sum;
    logic [CW-1:0] w_shl;
    logic [LW-1:0] w_step_nxt;
    logic [KW-1:0] w_kinc;
    logic [CW-1:0] w_mask;
    logic          w_len_nz;

    assign w_len_nz   = (i_ctl.len != '0);
    assign w_hidx     = i_ctl.hist_en ? i_ctl.len : i_ctl.step_idx;
    assign w_hval     = r_hist[w_hidx];
    assign w_nval     = r_next[i_ctl.len];
    assign w_step_nxt = i_ctl.step_idx + LW'(1);

    // shared adder: histogram count, first-code step, next-code bump
    always_comb begin
        w_a = w_nval;
        w_b = CW'(1);
        if (i_ctl.hist_en) begin
            w_a = CW'(w_hval);
            w_b = CW'(1);
        end else if (i_ctl.step_en) begin
            w_a = r_code;
            w_b = CW'(w_hval);
        end
    end

    assign w_sum = w_a + w_b;
    assign w_shl = {w_sum[CW-2:0], 1'b0};

    // kraft sum scaled to the length limit
    assign w_kinc = KW'(1) << (LW'(LEN_LIMIT) - i_ctl.len);

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_hist  <= '{default: '0};
            r_next  <= '{default: '0};
            r_code  <= '0;
            r_kraft <= '0;
        end else begin
            if (i_ctl.hist_en && w_len_nz) begin
                r_hist[i_ctl.len] <= w_sum[HW-1:0];
                r_kraft           <= r_kraft + w_kinc;
            end
            if (i_ctl.step_en) begin
                r_code             <= w_shl;
                r_next[w_step_nxt] <= w_shl;
            end
            if (i_ctl.assign_en && w_len_nz) begin
                r_next[i_ctl.len] <= w_sum;
            end
        end
    end

    assign w_mask    = {CW{1'b1}} >> (LW'(CW) - i_ctl.len);
    assign o_code    = w_nval & w_mask;
    assign o_oversub = (r_kraft > KRAFT_FULL);

endmodule

// ----- hw/rtl/canonical_huffman_code_builder_unit.sv -----
// canonical huffman code builder
// input channel (i_in_valid / o_in_stall / i_in_data): load beats write one
// symbol's code length, query beats ask for a symbol's code. output channel
// (o_out_valid / i_out_stall / o_out_data): one beat per query, none per load.
// the load beat with last set starts the build pass, which holds o_in_stall
// high through one walk of the length store to count lengths and the kraft
// sum, 15 steps of the shared adder for the first code of each length, and a
// second walk that hands out codes. DEPTH is NUM_SYMBOLS, capped at 256. a
// query's result beat passes the length and code memory read registers, then
// the output register; a new query is not taken while one is in flight. the
// first load after a finished build empties the length store in the same
// cycle. reset (synchronous, active low) empties the length store, drops the
// built and oversubscribed flags and the output beat. while the receiver
// stalls the output beat holds, and a new query waits until it has been taken.
module canonical_huffman_code_builder_unit #(
    parameter int NUM_SYMBOLS  = 256,
    parameter int MAX_CODE_LEN = 15
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  chcb_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output chcb_pkg::t_out  o_out_data
);

    localparam int DEPTH     = (NUM_SYMBOLS < 256) ? NUM_SYMBOLS : 256;
    localparam int AW        = $clog2(DEPTH);
    localparam int CNTW      = ((AW + 1) > 4) ? (AW + 1) : 4;
    localparam int LEN_LIMIT = (MAX_CODE_LEN < 15) ? MAX_CODE_LEN : 15;
    localparam int LW        = chcb_pkg::LEN_W;
    localparam int CW        = chcb_pkg::CODE_W;
    localparam logic [LW-1:0]   LEN_MAX   = LW'(LEN_LIMIT);
    localparam logic [CNTW-1:0] CNT_END   = CNTW'(DEPTH);
    localparam logic [CNTW-1:0] STEP_LAST = CNTW'(chcb_pkg::NUM_STEPS - 1);

    chcb_pkg::t_state   r_state, n_state;
    logic [CNTW-1:0]    r_cnt, n_cnt;
    logic               r_rd_vld, n_rd_vld;
    logic [AW-1:0]      r_rd_idx;
    logic               r_built, n_built;
    logic               r_ovf, n_ovf;
    logic               r_q_pend;
    logic               r_q_inr;
    logic               r_out_vld;
    chcb_pkg::t_out     r_out;
    logic [CW-1:0]      r_code_mem [DEPTH];
    logic [CW-1:0]      r_code_rd;

    chcb_pkg::t_gen_ctl w_ctl;
    chcb_pkg::t_out     w_res;
    logic               w_accept;
    logic               w_load;
    logic               w_query;
    logic               w_in_range;
    logic [AW-1:0]      w_sym_idx;
    logic [LW-1:0]      w_len_sat;
    logic [LW-1:0]      w_len_rd;
    logic [AW-1:0]      w_raddr;
    logic               w_st_clear;
    logic               w_st_we;
    logic               w_code_we;
    logic [CW-1:0]      w_gen_code;
    logic               w_gen_ovf;
    logic [LW-1:0]      w_bits;

    // input handshake
    assign o_in_stall = (r_state != chcb_pkg::S_IDLE) || r_q_pend ||
                        (r_out_vld && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_load     = w_accept && (i_in_data.op == chcb_pkg::OP_LOAD);
    assign w_query    = w_accept && (i_in_data.op == chcb_pkg::OP_QUERY);

    // symbols past the store are dropped on load and read as unused
    assign w_in_range = ({1'b0, i_in_data.symbol} < 9'(DEPTH));
    assign w_sym_idx  = i_in_data.symbol[AW-1:0];
    assign w_len_sat  = (i_in_data.code_length > LEN_MAX) ? LEN_MAX
                                                          : i_in_data.code_length;

    // sequencer: idle, count lengths, first codes, hand out codes
    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_rd_vld       = 1'b0;
        n_built        = r_built;
        n_ovf          = r_ovf;
        w_ctl          = '0;
        w_ctl.len      = w_len_rd;
        w_ctl.step_idx = r_cnt[LW-1:0];
        w_code_we      = 1'b0;
        case (r_state)
            chcb_pkg::S_IDLE: begin
                if (w_load) begin
                    if (r_built) begin
                        n_built = 1'b0;
                        n_ovf   = 1'b0;
                    end
                    if (i_in_data.last) begin
                        n_state     = chcb_pkg::S_HIST;
                        n_cnt       = '0;
                        w_ctl.clear = 1'b1;
                    end
                end
            end
            chcb_pkg::S_HIST: begin
                w_ctl.hist_en = r_rd_vld;
                if (r_cnt < CNT_END) begin
                    n_cnt    = r_cnt + CNTW'(1);
                    n_rd_vld = 1'b1;
                end else if (!r_rd_vld) begin
                    n_state = chcb_pkg::S_STEP;
                    n_cnt   = '0;
                end
            end
            chcb_pkg::S_STEP: begin
                w_ctl.step_en = 1'b1;
                if (r_cnt == STEP_LAST) begin
                    n_state = chcb_pkg::S_ASSIGN;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNTW'(1);
                end
            end
            chcb_pkg::S_ASSIGN: begin
                w_ctl.assign_en = r_rd_vld;
                w_code_we       = r_rd_vld && (w_len_rd != '0);
                if (r_cnt < CNT_END) begin
                    n_cnt    = r_cnt + CNTW'(1);
                    n_rd_vld = 1'b1;
                end else if (!r_rd_vld) begin
                    n_state = chcb_pkg::S_IDLE;
                    n_cnt   = '0;
                    n_built = 1'b1;
                    n_ovf   = w_gen_ovf;
                end
            end
            default: begin
                n_state = chcb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= chcb_pkg::S_IDLE;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_built  <= 1'b0;
            r_ovf    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rd_vld <= n_rd_vld;
            r_built  <= n_built;
            r_ovf    <= n_ovf;
        end
    end

    // index of the length that arrives next cycle
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_cnt[AW-1:0];
    end

    // length store: written by loads, read by queries and both walks
    assign w_st_clear = w_load && r_built;
    assign w_st_we    = w_load && w_in_range;
    assign w_raddr    = (r_state == chcb_pkg::S_IDLE) ? w_sym_idx : r_cnt[AW-1:0];

    chcb_len_store #(
        .DEPTH (DEPTH)
    ) u_len_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_st_clear),
        .i_we    (w_st_we),
        .i_waddr (w_sym_idx),
        .i_wdata (w_len_sat),
        .i_raddr (w_raddr),
        .o_rdata (w_len_rd)
    );

    // histogram, first codes and next codes around one shared adder, plus the kraft sum
    chcb_code_gen #(
        .DEPTH     (DEPTH),
        .LEN_LIMIT (LEN_LIMIT)
    ) u_code_gen (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .o_code    (w_gen_code),
        .o_oversub (w_gen_ovf)
    );

    // code memory: written during the second walk, read by queries
    always_ff @(posedge i_clk) begin
        if (w_code_we) begin
            r_code_mem[r_rd_idx] <= w_gen_code;
        end
        r_code_rd <= r_code_mem[w_sym_idx];
    end

    // query in flight: memory reads land in the cycle after acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_pend <= 1'b0;
        end else begin
            r_q_pend <= w_query;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_q_inr <= w_in_range;
        end
    end

    // result of the query; the code counts only after a build
    always_comb begin
        w_bits               = r_q_inr ? w_len_rd : '0;
        w_res.code           = (r_built && (w_bits != '0)) ? r_code_rd : '0;
        w_res.code_bits      = w_bits;
        w_res.present        = (w_bits != '0);
        w_res.oversubscribed = r_ovf;
    end

    // output register, holds its beat while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_q_pend) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_q_pend) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // a query in flight always lands in the output register
    a_query_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_pend |=> r_out_vld)
        else $error("query result did not reach the output register");

    // a final load always starts the counting walk
    a_last_starts_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && i_in_data.last) |=> (r_state == chcb_pkg::S_HIST))
        else $error("final load did not start the build");

    // the code memory is only written by the assignment walk
    a_code_we_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_code_we |-> (r_state == chcb_pkg::S_ASSIGN))
        else $error("code memory written outside the assignment walk");

    // a query never overwrites a beat that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |-> !r_q_pend)
        else $error("query result would overwrite a stalled beat");

    // the build flag is only set at the end of the assignment walk
    a_built_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_built && n_built) |-> (r_state == chcb_pkg::S_ASSIGN))
        else $error("built flag set outside the assignment walk");

endmodule
